// ----- sv/wva_pkg.sv -----
package wva_pkg;

   // fixed point constants
   localparam logic [29:0] INV_K = 30'd652032874;  // 1/K of the cordic, 30 fraction bits
   localparam logic [14:0] DIR_FULL = 15'd23040;   // 360 degrees, 6 fraction bits
   localparam int GUARD = 14;

   // datapath widths
   localparam int XY_W = 42;      // cordic x and y
   localparam int Z_W = 26;       // cordic angle, degrees with 16 fraction bits
   localparam int MUL_W = 27;     // multiplier bits of the shift-add multiplier
   localparam int PROD_W = 57;    // product width, MUL_W + 30
   localparam int DIV_W = 39;     // dividend bits, 25 bit sum with 14 guard bits
   localparam int STEP_W = 6;     // step counter of the sequencer
   localparam int SUM_W = 25;
   localparam int RAIN_W = 22;

   localparam logic signed [Z_W-1:0] ANG_90 = 26'sd5898240;
   localparam logic signed [Z_W-1:0] ANG_180 = 26'sd11796480;
   localparam logic signed [Z_W-1:0] ANG_360 = 26'sd23592960;

   localparam logic signed [SUM_W-1:0] SUM_MAX = 25'sd16777215;
   localparam logic signed [SUM_W-1:0] SUM_MIN = -25'sd16777216;

   // selects which sum the divider works on
   typedef logic [1:0] div_sel_type;
   localparam div_sel_type DSEL_NORTH = 2'd0;
   localparam div_sel_type DSEL_EAST = 2'd1;
   localparam div_sel_type DSEL_RAIN = 2'd2;

   typedef logic [21:0] angle_step_type;

   // arctangent of 2^-i, degrees with 16 fraction bits
   function automatic angle_step_type atan_lookup(input logic [4:0] idx);
      angle_step_type val;
      case (idx)
         5'd0: val = 22'd2949120;
         5'd1: val = 22'd1740967;
         5'd2: val = 22'd919879;
         5'd3: val = 22'd466945;
         5'd4: val = 22'd234379;
         5'd5: val = 22'd117304;
         5'd6: val = 22'd58666;
         5'd7: val = 22'd29335;
         5'd8: val = 22'd14668;
         5'd9: val = 22'd7334;
         5'd10: val = 22'd3667;
         5'd11: val = 22'd1833;
         5'd12: val = 22'd917;
         5'd13: val = 22'd458;
         5'd14: val = 22'd229;
         5'd15: val = 22'd115;
         5'd16: val = 22'd57;
         5'd17: val = 22'd29;
         5'd18: val = 22'd14;
         5'd19: val = 22'd7;
         5'd20: val = 22'd4;
         5'd21: val = 22'd2;
         5'd22: val = 22'd1;
         default: val = 22'd0;
      endcase
      return val;
   endfunction

endpackage

// ----- sv/wind_vector_averager_top.sv -----
// a plain sample runs through the serial multiplier, the cordic rotation and the sum
// a minute-end sample then runs three divisions (north, east, rain), the cordic vectoring,
// a second pass through the multiplier and the output step
// throughput: one transaction at a time, set by the single cordic and the serial multiplier
// the result register frees the input side while a result waits, until the next result is due
// reset (synchronous, active high) clears all sums, the sample count and the sequencer
module wind_vector_averager_top #(
   parameter int MAX_SAMPLES = 64,
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_wind_speed,
   input  logic [14:0] req_wind_direction,
   input  logic [15:0] req_rain_amount,
   input  logic        req_minute_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_avg_speed,
   output logic [14:0] rsp_avg_direction,
   output logic [15:0] rsp_avg_rain,
   output logic [6:0]  rsp_sample_count
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int XY_W = wva_pkg::XY_W;
   localparam int Z_W = wva_pkg::Z_W;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SMUL = 4'd1;
   localparam logic [3:0] ST_RSET = 4'd2;
   localparam logic [3:0] ST_ROT = 4'd3;
   localparam logic [3:0] ST_ACC = 4'd4;
   localparam logic [3:0] ST_DSET = 4'd5;
   localparam logic [3:0] ST_DIV = 4'd6;
   localparam logic [3:0] ST_DSTO = 4'd7;
   localparam logic [3:0] ST_VSET = 4'd8;
   localparam logic [3:0] ST_VEC = 4'd9;
   localparam logic [3:0] ST_MSET = 4'd10;
   localparam logic [3:0] ST_MMUL = 4'd11;
   localparam logic [3:0] ST_FIN = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [wva_pkg::STEP_W-1:0] step_ff, step_in;
   logic done_ff, done_in;
   logic neg_ff, neg_in;
   logic signed [wva_pkg::SUM_W-1:0] north_sum_ff, north_sum_in;
   logic signed [wva_pkg::SUM_W-1:0] east_sum_ff, east_sum_in;
   logic [wva_pkg::RAIN_W-1:0] rain_sum_ff, rain_sum_in;
   logic [CNT_W-1:0] samples_ff, samples_in;
   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0] z_ff, z_in;
   logic [wva_pkg::MUL_W-1:0] mplier_ff, mplier_in;
   logic [wva_pkg::PROD_W-1:0] mcand_ff, mcand_in, prod_ff, prod_in;
   wva_pkg::div_sel_type div_sel_ff, div_sel_in;
   logic [wva_pkg::DIV_W-1:0] dq_ff, dq_in;
   logic [CNT_W-1:0] drem_ff, drem_in;
   logic dneg_ff, dneg_in;
   logic [wva_pkg::RAIN_W-1:0] rain_q_ff, rain_q_in;
   logic zero_ff, zero_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [15:0] speed_ff, speed_in;
   logic [14:0] dir_ff, dir_in;
   logic [15:0] rain_ff, rain_in;
   logic [6:0] count_ff, count_in;

   // rain of the accepted transaction is held for the accumulate step
   logic [15:0] req_rain_amount_hold;
   logic [15:0] rain_hold_ff, rain_hold_in;

   // input angle preparation
   logic [14:0] dir_red;
   logic signed [Z_W-1:0] ang0, ang1, ang2;
   logic ang_neg;

   // cordic step
   logic [4:0] cidx;
   logic signed [XY_W-1:0] cdx, cdy;
   logic signed [Z_W-1:0] cat;
   logic cup;

   // accumulate
   logic signed [XY_W-1:0] cx, sy, cx_r, sy_r;
   logic signed [27:0] rnd_n, rnd_e;
   logic signed [28:0] n_wide, e_wide;
   logic [22:0] r_wide;

   // divider
   logic [CNT_W:0] r_sh, r_sub;
   logic r_ge;
   logic signed [XY_W-1:0] q_signed;
   logic [wva_pkg::SUM_W-1:0] div_mag;

   // result
   logic [41:0] m_q;
   logic [42:0] m_r;
   logic [28:0] m_g;
   logic signed [26:0] z_r;
   logic signed [16:0] d_raw;
   logic [14:0] d_wrap;
   logic signed [XY_W-1:0] x_pos;

   logic req_fire, out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_rain_amount_hold = rain_hold_ff;

   // fold the input direction into +-90 degrees for the rotation
   always_comb begin
      dir_red = (req_wind_direction >= wva_pkg::DIR_FULL) ?
                req_wind_direction - wva_pkg::DIR_FULL : req_wind_direction;
      ang0 = {1'b0, dir_red, 10'b0};
      ang1 = (ang0 > wva_pkg::ANG_180) ? ang0 - wva_pkg::ANG_360 : ang0;
      ang_neg = 1'b0;
      ang2 = ang1;
      if (ang1 > wva_pkg::ANG_90) begin
         ang2 = ang1 - wva_pkg::ANG_180;
         ang_neg = 1'b1;
      end else if (ang1 < -wva_pkg::ANG_90) begin
         ang2 = ang1 + wva_pkg::ANG_180;
         ang_neg = 1'b1;
      end
   end

   // shared cordic micro-rotation, rotation mode steers by z, vectoring by y
   always_comb begin
      cidx = step_ff[4:0];
      cdx = y_ff >>> cidx;
      cdy = x_ff >>> cidx;
      cat = Z_W'(wva_pkg::atan_lookup(cidx));
      cup = (state_ff == ST_ROT) ? !z_ff[Z_W-1] : y_ff[XY_W-1];
   end

   // rounding and saturating accumulation of the components
   always_comb begin
      cx = neg_ff ? -x_ff : x_ff;
      sy = neg_ff ? -y_ff : y_ff;
      cx_r = cx + XY_W'(1 << (wva_pkg::GUARD - 1));
      sy_r = sy + XY_W'(1 << (wva_pkg::GUARD - 1));
      rnd_n = cx_r[41:14];
      rnd_e = sy_r[41:14];
      n_wide = 29'(north_sum_ff) + 29'(rnd_n);
      e_wide = 29'(east_sum_ff) + 29'(rnd_e);
      r_wide = 23'(rain_sum_ff) + 23'(req_rain_amount_hold);
   end

   // restoring divider step and operand pick
   always_comb begin
      r_sh = {drem_ff, dq_ff[wva_pkg::DIV_W-1]};
      r_ge = (r_sh >= {1'b0, samples_ff});
      r_sub = r_sh - {1'b0, samples_ff};
      q_signed = dneg_ff ? -XY_W'(dq_ff) : XY_W'(dq_ff);
      div_mag = (div_sel_ff == wva_pkg::DSEL_NORTH) ?
                (north_sum_ff[24] ? -north_sum_ff : north_sum_ff) :
                (east_sum_ff[24] ? -east_sum_ff : east_sum_ff);
   end

   // final scaling of magnitude and angle
   always_comb begin
      x_pos = x_ff[XY_W-1] ? '0 : x_ff;
      m_q = prod_ff[56:15];
      m_r = 43'(m_q) + 43'd8192;
      m_g = m_r[42:14];
      z_r = 27'(z_ff) + 27'sd512;
      d_raw = z_r[26:10];
      if (d_raw < 0) begin
         d_wrap = 15'(d_raw + 17'sd23040);
      end else if (d_raw >= 17'sd23040) begin
         d_wrap = 15'(d_raw - 17'sd23040);
      end else begin
         d_wrap = d_raw[14:0];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      done_in = done_ff;
      neg_in = neg_ff;
      north_sum_in = north_sum_ff;
      east_sum_in = east_sum_ff;
      rain_sum_in = rain_sum_ff;
      samples_in = samples_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      mplier_in = mplier_ff;
      mcand_in = mcand_ff;
      prod_in = prod_ff;
      div_sel_in = div_sel_ff;
      dq_in = dq_ff;
      drem_in = drem_ff;
      dneg_in = dneg_ff;
      rain_q_in = rain_q_ff;
      zero_in = zero_ff;
      rain_hold_in = rain_hold_ff;
      rsp_valid_in = rsp_valid_ff;
      speed_in = speed_ff;
      dir_in = dir_ff;
      rain_in = rain_ff;
      count_in = count_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_fire) begin
               done_in = req_minute_end;
               rain_hold_in = req_rain_amount;
               div_sel_in = wva_pkg::DSEL_NORTH;
               if (samples_ff < CNT_W'(MAX_SAMPLES)) begin
                  mplier_in = wva_pkg::MUL_W'(req_wind_speed) + 1'b1;
                  mcand_in = wva_pkg::PROD_W'(wva_pkg::INV_K);
                  prod_in = '0;
                  step_in = '0;
                  z_in = ang2;
                  neg_in = ang_neg;
                  state_in = ST_SMUL;
               end else if (req_minute_end) begin
                  state_in = ST_DSET;
               end
            end
         end
         ST_SMUL, ST_MMUL: begin
            if (mplier_ff[0]) begin
               prod_in = prod_ff + mcand_ff;
            end
            mcand_in = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == wva_pkg::STEP_W'(wva_pkg::MUL_W - 1)) begin
               state_in = (state_ff == ST_SMUL) ? ST_RSET : ST_FIN;
            end
         end
         ST_RSET: begin
            x_in = XY_W'(prod_ff[45:16]);
            y_in = '0;
            step_in = '0;
            state_in = ST_ROT;
         end
         ST_ROT, ST_VEC: begin
            if (cup) begin
               x_in = x_ff - cdx;
               y_in = y_ff + cdy;
               z_in = z_ff - cat;
            end else begin
               x_in = x_ff + cdx;
               y_in = y_ff - cdy;
               z_in = z_ff + cat;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == wva_pkg::STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = (state_ff == ST_ROT) ? ST_ACC : ST_MSET;
            end
         end
         ST_ACC: begin
            if (n_wide > 29'(wva_pkg::SUM_MAX)) begin
               north_sum_in = wva_pkg::SUM_MAX;
            end else if (n_wide < 29'(wva_pkg::SUM_MIN)) begin
               north_sum_in = wva_pkg::SUM_MIN;
            end else begin
               north_sum_in = n_wide[24:0];
            end
            if (e_wide > 29'(wva_pkg::SUM_MAX)) begin
               east_sum_in = wva_pkg::SUM_MAX;
            end else if (e_wide < 29'(wva_pkg::SUM_MIN)) begin
               east_sum_in = wva_pkg::SUM_MIN;
            end else begin
               east_sum_in = e_wide[24:0];
            end
            rain_sum_in = r_wide[22] ? '1 : r_wide[21:0];
            samples_in = samples_ff + 1'b1;
            state_in = done_ff ? ST_DSET : ST_IDLE;
         end
         ST_DSET: begin
            if (div_sel_ff == wva_pkg::DSEL_RAIN) begin
               dq_in = wva_pkg::DIV_W'(rain_sum_ff);
               dneg_in = 1'b0;
            end else begin
               dq_in = {div_mag, 14'b0};
               dneg_in = (div_sel_ff == wva_pkg::DSEL_NORTH) ?
                         north_sum_ff[24] : east_sum_ff[24];
            end
            drem_in = '0;
            step_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            drem_in = r_ge ? r_sub[CNT_W-1:0] : r_sh[CNT_W-1:0];
            dq_in = {dq_ff[wva_pkg::DIV_W-2:0], r_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == wva_pkg::STEP_W'(wva_pkg::DIV_W - 1)) begin
               state_in = ST_DSTO;
            end
         end
         ST_DSTO: begin
            case (div_sel_ff)
               wva_pkg::DSEL_NORTH: begin
                  x_in = q_signed;
                  div_sel_in = wva_pkg::DSEL_EAST;
                  state_in = ST_DSET;
               end
               wva_pkg::DSEL_EAST: begin
                  y_in = q_signed;
                  div_sel_in = wva_pkg::DSEL_RAIN;
                  state_in = ST_DSET;
               end
               default: begin
                  rain_q_in = dq_ff[wva_pkg::RAIN_W-1:0];
                  state_in = ST_VSET;
               end
            endcase
         end
         ST_VSET: begin
            zero_in = (x_ff == '0) && (y_ff == '0);
            if (x_ff[XY_W-1]) begin
               x_in = -x_ff;
               y_in = -y_ff;
               z_in = wva_pkg::ANG_180;
            end else begin
               z_in = '0;
            end
            step_in = '0;
            state_in = ST_VEC;
         end
         ST_MSET: begin
            mplier_in = x_pos[41:15];
            mcand_in = wva_pkg::PROD_W'(wva_pkg::INV_K);
            prod_in = '0;
            step_in = '0;
            state_in = ST_MMUL;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (samples_ff == '0 || zero_ff) begin
                  speed_in = '0;
                  dir_in = '0;
               end else begin
                  speed_in = (m_g > 29'd65535) ? 16'hffff : m_g[15:0];
                  dir_in = d_wrap;
               end
               if (samples_ff == '0) begin
                  rain_in = '0;
               end else begin
                  rain_in = (rain_q_ff > 22'd65535) ? 16'hffff : rain_q_ff[15:0];
               end
               count_in = 7'(samples_ff);
               north_sum_in = '0;
               east_sum_in = '0;
               rain_sum_in = '0;
               samples_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         north_sum_ff <= '0;
         east_sum_ff <= '0;
         rain_sum_ff <= '0;
         samples_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         north_sum_ff <= north_sum_in;
         east_sum_ff <= east_sum_in;
         rain_sum_ff <= rain_sum_in;
         samples_ff <= samples_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      done_ff <= done_in;
      neg_ff <= neg_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      mplier_ff <= mplier_in;
      mcand_ff <= mcand_in;
      prod_ff <= prod_in;
      div_sel_ff <= div_sel_in;
      dq_ff <= dq_in;
      drem_ff <= drem_in;
      dneg_ff <= dneg_in;
      rain_q_ff <= rain_q_in;
      zero_ff <= zero_in;
      rain_hold_ff <= rain_hold_in;
      speed_ff <= speed_in;
      dir_ff <= dir_in;
      rain_ff <= rain_in;
      count_ff <= count_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_avg_speed = speed_ff;
   assign rsp_avg_direction = dir_ff;
   assign rsp_avg_rain = rain_ff;
   assign rsp_sample_count = count_ff;

   // sample count never passes its limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      samples_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count above limit");

   // a waiting result is never overwritten by a new one
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(speed_ff) && $stable(dir_ff)))
      else $error("pending result overwritten");

   // issuing a result clears the period and frees the input
   a_period_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && out_free) |=>
         (samples_ff == '0 && rain_sum_ff == '0 && state_ff == ST_IDLE && rsp_valid_ff))
      else $error("period not cleared after result");

   // reported direction stays in 0 to below 360 degrees
   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (dir_ff < wva_pkg::DIR_FULL))
      else $error("direction out of range");

endmodule
